// ===== hw/rtl/tlq_pkg.sv =====
// tlq_pkg: shared constants, types and codes of the two-level queue
// with timed entries; no dependencies
package tlq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int FUTURE_DEPTH = 16;
    localparam int ITEM_WIDTH   = 32;

    localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int FIDX_W  = (FUTURE_DEPTH > 1) ? $clog2(FUTURE_DEPTH) : 1;
    localparam int FCNT_W  = $clog2(FUTURE_DEPTH + 1);
    localparam int DSUM_W  = ((QCNT_W > FCNT_W) ? QCNT_W : FCNT_W) + 1;

    localparam int REQ_W     = 3;
    localparam int HANDLE_W  = 32;
    localparam int DELAY_W   = 16;
    localparam int DROP_W    = 6;
    localparam int TIME_W    = 32;
    localparam int DROP_MAX  = (1 << DROP_W) - 1;

    typedef logic [ITEM_WIDTH-1:0] item_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_HIGH   = 3'd0,
        REQ_PUSH_LOW    = 3'd1,
        REQ_PUSH_FUTURE = 3'd2,
        REQ_GET         = 3'd3,
        REQ_TICK        = 3'd4,
        REQ_CHECK       = 3'd5
    } req_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_ctl_t;

endpackage

// ===== hw/rtl/tlq_if.sv =====
// tlq_req_if and tlq_res_if: valid/ready channels of the queue block
// depends on tlq_pkg
interface tlq_req_if;
    logic                         valid;
    logic                         ready;
    logic [tlq_pkg::REQ_W-1:0]    req_type;
    logic [tlq_pkg::HANDLE_W-1:0] item;
    logic [tlq_pkg::DELAY_W-1:0]  delay_ms;
    logic                         purge_on_high;

    modport source (output valid, req_type, item, delay_ms, purge_on_high, input ready);
    modport sink (input valid, req_type, item, delay_ms, purge_on_high, output ready);
endinterface

interface tlq_res_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [tlq_pkg::HANDLE_W-1:0] out_item;
    logic                         was_high;
    logic [tlq_pkg::DROP_W-1:0]   dropped_count;
    logic                         ready_res;
    logic                         rejected;

    modport source (output valid, found, out_item, was_high, dropped_count, ready_res,
                    rejected, input ready);
    modport sink (input valid, found, out_item, was_high, dropped_count, ready_res,
                  rejected, output ready);
endinterface

// ===== hw/rtl/two_level_queue_with_timed_entries.sv =====
// two_level_queue_with_timed_entries: high and low fifos plus a timed store
// depends on tlq_pkg, tlq_if (tlq_req_if, tlq_res_if) and tlq_fifo
//
//  channel  dir  carries
//  req      in   req_type, item, delay_ms, purge_on_high
//  res      out  found, out_item, was_high, dropped_count, ready_res, rejected
//
// push, tick and unused codes are answered straight from idle; the result lands in the output register.
// get and check run the promotion sequencer: one timed entry compared per cycle
// through the shared compare unit, then one entry shifted per cycle on removal,
// repeated for each promoted item while the low fifo has room.
// reset clears counts and time; stores hold no reset value.
// a new request is taken while idle once the output register is free or draining.
module two_level_queue_with_timed_entries (
    input logic     clk,
    input logic     rst_n,
    tlq_req_if.sink   req,
    tlq_res_if.source res
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_MOVE   = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [tlq_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [tlq_pkg::FCNT_W-1:0]     hcount_reg, hcount_next;
    logic [tlq_pkg::FIDX_W-1:0]     idx_reg, idx_next;
    logic [tlq_pkg::FIDX_W-1:0]     best_reg, best_next;
    logic signed [tlq_pkg::TIME_W-1:0] best_dist_reg, best_dist_next;
    logic                           get_reg, get_next;
    logic                           purge_reg, purge_next;

    logic                           res_valid_reg, res_valid_next;
    logic                           found_reg, found_next;
    logic [tlq_pkg::HANDLE_W-1:0]   out_item_reg, out_item_next;
    logic                           was_high_reg, was_high_next;
    logic [tlq_pkg::DROP_W-1:0]     dropped_reg, dropped_next;
    logic                           ready_res_reg, ready_res_next;
    logic                           rejected_reg, rejected_next;

    logic [tlq_pkg::TIME_W-1:0]     due_mem [tlq_pkg::FUTURE_DEPTH];
    tlq_pkg::item_t                 fitem_mem [tlq_pkg::FUTURE_DEPTH];
    logic [tlq_pkg::FIDX_W-1:0]     rd_addr, wr_addr;
    logic [tlq_pkg::TIME_W-1:0]     rd_due, wr_due;
    tlq_pkg::item_t                 rd_item, wr_item;
    logic                           wr_en;
    logic signed [tlq_pkg::TIME_W-1:0] cur_gap, final_dist;

    tlq_pkg::fifo_ctl_t             hi_ctl, lo_ctl;
    tlq_pkg::item_t                 hi_rd, lo_rd, lo_wr, in_item;
    logic [tlq_pkg::QCNT_W-1:0]     hi_cnt, lo_cnt;
    logic                           hi_full, lo_full, accept, last, take;
    logic [tlq_pkg::DSUM_W-1:0]     drop_sum;

    tlq_fifo u_high (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (hi_ctl),
        .wr_data (in_item),
        .rd_data (hi_rd),
        .count   (hi_cnt)
    );

    tlq_fifo u_low (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lo_ctl),
        .wr_data (lo_wr),
        .rd_data (lo_rd),
        .count   (lo_cnt)
    );

    assign req.ready = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);
    assign accept    = req.valid && req.ready;
    assign in_item   = tlq_pkg::item_t'(req.item);
    assign hi_full   = (hi_cnt == tlq_pkg::QCNT_W'(tlq_pkg::QUEUE_DEPTH));
    assign lo_full   = (lo_cnt == tlq_pkg::QCNT_W'(tlq_pkg::QUEUE_DEPTH));
    assign drop_sum  = tlq_pkg::DSUM_W'(lo_cnt) + tlq_pkg::DSUM_W'(hcount_reg);

    // shared read port of the timed store
    always_comb
    begin
        case (state_reg)
            ST_MOVE:  rd_addr = best_reg;
            ST_SHIFT: rd_addr = idx_reg + 1'b1;
            default:  rd_addr = idx_reg;
        endcase
    end

    assign rd_due  = due_mem[rd_addr];
    assign rd_item = fitem_mem[rd_addr];
    assign cur_gap = signed'(rd_due - now_reg);
    assign last    = (tlq_pkg::FCNT_W'(idx_reg) + 1'b1) == hcount_reg;
    assign take    = (idx_reg == '0) || (cur_gap < best_dist_reg);
    assign final_dist = take ? cur_gap : best_dist_reg;

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        hcount_next    = hcount_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_dist_next = best_dist_reg;
        get_next       = get_reg;
        purge_next     = purge_reg;
        hi_ctl         = '0;
        lo_ctl         = '0;
        lo_wr          = in_item;
        wr_en          = 1'b0;
        wr_addr        = hcount_reg[tlq_pkg::FIDX_W-1:0];
        wr_due         = now_reg + tlq_pkg::TIME_W'(req.delay_ms);
        wr_item        = in_item;
        res_valid_next = res_valid_reg && !res.ready;
        found_next     = found_reg;
        out_item_next  = out_item_reg;
        was_high_next  = was_high_reg;
        dropped_next   = dropped_reg;
        ready_res_next = ready_res_reg;
        rejected_next  = rejected_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next     = 1'b0;
                    out_item_next  = '0;
                    was_high_next  = 1'b0;
                    dropped_next   = '0;
                    rejected_next  = 1'b0;
                    ready_res_next = (hi_cnt != '0) || (lo_cnt != '0);
                    res_valid_next = 1'b1;
                    case (tlq_pkg::req_t'(req.req_type))
                        tlq_pkg::REQ_PUSH_HIGH:
                        begin
                            rejected_next  = hi_full;
                            hi_ctl.push    = !hi_full;
                            ready_res_next = ready_res_next || !hi_full;
                        end
                        tlq_pkg::REQ_PUSH_LOW:
                        begin
                            rejected_next  = lo_full;
                            lo_ctl.push    = !lo_full;
                            ready_res_next = ready_res_next || !lo_full;
                        end
                        tlq_pkg::REQ_PUSH_FUTURE:
                        begin
                            if (hcount_reg == tlq_pkg::FCNT_W'(tlq_pkg::FUTURE_DEPTH))
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                hcount_next = hcount_reg + 1'b1;
                            end
                        end
                        tlq_pkg::REQ_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        tlq_pkg::REQ_GET, tlq_pkg::REQ_CHECK:
                        begin
                            res_valid_next = 1'b0;
                            get_next   = (req.req_type == tlq_pkg::REQ_GET);
                            purge_next = req.purge_on_high;
                            idx_next   = '0;
                            state_next = ((hcount_reg != '0) && !lo_full) ? ST_SCAN
                                                                           : ST_FINISH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    best_next      = idx_reg;
                    best_dist_next = cur_gap;
                end
                if (last)
                begin
                    state_next = (final_dist > 0) ? ST_FINISH : ST_MOVE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MOVE:
            begin
                lo_ctl.push = 1'b1;
                lo_wr       = rd_item;
                idx_next    = best_reg;
                state_next  = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (!last)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_due   = rd_due;
                    wr_item  = rd_item;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    hcount_next = hcount_reg - 1'b1;
                    idx_next    = '0;
                    state_next  = ((hcount_reg != tlq_pkg::FCNT_W'(1)) && !lo_full)
                                  ? ST_SCAN : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                found_next     = 1'b0;
                out_item_next  = '0;
                was_high_next  = 1'b0;
                dropped_next   = '0;
                rejected_next  = 1'b0;
                ready_res_next = (hi_cnt != '0) || (lo_cnt != '0);
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (get_reg)
                begin
                    if (hi_cnt != '0)
                    begin
                        hi_ctl.pop    = 1'b1;
                        found_next    = 1'b1;
                        was_high_next = 1'b1;
                        out_item_next = tlq_pkg::HANDLE_W'(hi_rd);
                        ready_res_next = (hi_cnt != tlq_pkg::QCNT_W'(1)) ||
                                         (!purge_reg && (lo_cnt != '0));
                        if (purge_reg)
                        begin
                            lo_ctl.clear = 1'b1;
                            hcount_next  = '0;
                            dropped_next = (int'(drop_sum) > tlq_pkg::DROP_MAX)
                                           ? tlq_pkg::DROP_W'(tlq_pkg::DROP_MAX)
                                           : tlq_pkg::DROP_W'(drop_sum);
                        end
                    end
                    else if (lo_cnt != '0)
                    begin
                        lo_ctl.pop     = 1'b1;
                        found_next     = 1'b1;
                        out_item_next  = tlq_pkg::HANDLE_W'(lo_rd);
                        ready_res_next = (lo_cnt != tlq_pkg::QCNT_W'(1));
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            hcount_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            hcount_reg    <= hcount_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
        get_reg       <= get_next;
        purge_reg     <= purge_next;
        found_reg     <= found_next;
        out_item_reg  <= out_item_next;
        was_high_reg  <= was_high_next;
        dropped_reg   <= dropped_next;
        ready_res_reg <= ready_res_next;
        rejected_reg  <= rejected_next;
        if (wr_en)
        begin
            due_mem[wr_addr]   <= wr_due;
            fitem_mem[wr_addr] <= wr_item;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.found         = found_reg;
    assign res.out_item      = out_item_reg;
    assign res.was_high      = was_high_reg;
    assign res.dropped_count = dropped_reg;
    assign res.ready_res     = ready_res_reg;
    assign res.rejected      = rejected_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("request taken while sequencer busy");

    a_scan_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((hcount_reg != '0) && !lo_full))
        else $error("scan without timed entries or low room");

    a_move_then_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |=> ((state_reg == ST_SHIFT) && (lo_cnt != '0)))
        else $error("promotion did not reach the low fifo");

    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> res.valid)
        else $error("finished request left no result");

endmodule

// ===== hw/rtl/tlq_fifo.sv =====
// tlq_fifo: circular item fifo with push, pop and clear
// depends on tlq_pkg
module tlq_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tlq_pkg::fifo_ctl_t         ctl,
    input  tlq_pkg::item_t             wr_data,
    output tlq_pkg::item_t             rd_data,
    output logic [tlq_pkg::QCNT_W-1:0] count
);

    tlq_pkg::item_t                mem [tlq_pkg::QUEUE_DEPTH];
    logic [tlq_pkg::QIDX_W-1:0]    head_reg, head_next;
    logic [tlq_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic [tlq_pkg::QCNT_W:0]      tail_sum;
    logic [tlq_pkg::QIDX_W-1:0]    tail;

    always_comb
    begin
        tail_sum = (tlq_pkg::QCNT_W+1)'(head_reg) + (tlq_pkg::QCNT_W+1)'(count_reg);
        if (tail_sum >= (tlq_pkg::QCNT_W+1)'(tlq_pkg::QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - (tlq_pkg::QCNT_W+1)'(tlq_pkg::QUEUE_DEPTH);
        end
        tail = tail_sum[tlq_pkg::QIDX_W-1:0];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (ctl.pop)
            begin
                head_next = (head_reg == tlq_pkg::QIDX_W'(tlq_pkg::QUEUE_DEPTH - 1))
                            ? '0 : head_reg + 1'b1;
            end
            count_next = count_reg + tlq_pkg::QCNT_W'(ctl.push)
                         - tlq_pkg::QCNT_W'(ctl.pop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail] <= wr_data;
        end
    end

    assign rd_data = mem[head_reg];
    assign count   = count_reg;

endmodule

// ===== verif/two_level_queue_with_timed_entries_test.sv =====
`timescale 1ns / 1ps
// two_level_queue_with_timed_entries_test: self-checking bench for the two-level queue
// with timed entries; a scoreboard class tracks the high, low and timed stores
// depends on tlq_pkg, tlq_if and two_level_queue_with_timed_entries
module two_level_queue_with_timed_entries_test;

    localparam logic [tlq_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [tlq_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                         found;
        logic [tlq_pkg::HANDLE_W-1:0] out_item;
        logic                         was_high;
        logic [tlq_pkg::DROP_W-1:0]   dropped_count;
        logic                         ready_res;
        logic                         rejected;
    } outcome_t;

    class queue_scoreboard;
        tlq_pkg::item_t              hi_mem[tlq_pkg::QUEUE_DEPTH];
        int unsigned                 hi_head, hi_cnt;
        tlq_pkg::item_t              lo_mem[tlq_pkg::QUEUE_DEPTH];
        int unsigned                 lo_head, lo_cnt;
        logic [tlq_pkg::TIME_W-1:0]  due_at[tlq_pkg::FUTURE_DEPTH];
        tlq_pkg::item_t              timed_item[tlq_pkg::FUTURE_DEPTH];
        int unsigned                 timed_cnt;
        logic [tlq_pkg::TIME_W-1:0]  now_ms = '0;
        outcome_t                    pending[$];
        int                          errors;

        function logic signed [tlq_pkg::TIME_W-1:0] lead(logic [tlq_pkg::TIME_W-1:0] due);
            return due - now_ms;
        endfunction

        function void promote();
            int unsigned best;
            while (timed_cnt > 0 && lo_cnt < tlq_pkg::QUEUE_DEPTH) begin
                best = 0;
                for (int unsigned i = 1; i < timed_cnt; i++)
                    if (lead(due_at[i]) < lead(due_at[best]))
                        best = i;
                if (lead(due_at[best]) > 0)
                    break;
                lo_mem[(lo_head + lo_cnt) % tlq_pkg::QUEUE_DEPTH] = timed_item[best];
                lo_cnt++;
                for (int unsigned i = best; i + 1 < timed_cnt; i++) begin
                    due_at[i]     = due_at[i + 1];
                    timed_item[i] = timed_item[i + 1];
                end
                timed_cnt--;
            end
        endfunction

        function void note(logic [tlq_pkg::REQ_W-1:0] code,
                           logic [tlq_pkg::HANDLE_W-1:0] handle,
                           logic [tlq_pkg::DELAY_W-1:0] delay, logic purge);
            outcome_t o;
            int unsigned n;
            o = '0;
            case (code)
                tlq_pkg::REQ_PUSH_HIGH:
                    if (hi_cnt >= tlq_pkg::QUEUE_DEPTH)
                        o.rejected = 1'b1;
                    else
                    begin
                        hi_mem[(hi_head + hi_cnt) % tlq_pkg::QUEUE_DEPTH] = handle;
                        hi_cnt++;
                    end
                tlq_pkg::REQ_PUSH_LOW:
                    if (lo_cnt >= tlq_pkg::QUEUE_DEPTH)
                        o.rejected = 1'b1;
                    else
                    begin
                        lo_mem[(lo_head + lo_cnt) % tlq_pkg::QUEUE_DEPTH] = handle;
                        lo_cnt++;
                    end
                tlq_pkg::REQ_PUSH_FUTURE:
                    if (timed_cnt >= tlq_pkg::FUTURE_DEPTH)
                        o.rejected = 1'b1;
                    else
                    begin
                        due_at[timed_cnt]     = now_ms + delay;
                        timed_item[timed_cnt] = handle;
                        timed_cnt++;
                    end
                tlq_pkg::REQ_GET:
                begin
                    promote();
                    if (hi_cnt > 0)
                    begin
                        o.out_item = hi_mem[hi_head];
                        hi_head = (hi_head + 1) % tlq_pkg::QUEUE_DEPTH;
                        hi_cnt--;
                        o.found = 1'b1;
                        o.was_high = 1'b1;
                        if (purge)
                        begin
                            n = lo_cnt + timed_cnt;
                            o.dropped_count = tlq_pkg::DROP_W'((n > tlq_pkg::DROP_MAX)
                                              ? tlq_pkg::DROP_MAX : n);
                            lo_cnt = 0;
                            lo_head = 0;
                            timed_cnt = 0;
                        end
                    end
                    else if (lo_cnt > 0)
                    begin
                        o.out_item = lo_mem[lo_head];
                        lo_head = (lo_head + 1) % tlq_pkg::QUEUE_DEPTH;
                        lo_cnt--;
                        o.found = 1'b1;
                    end
                end
                tlq_pkg::REQ_TICK:
                    now_ms = now_ms + 1'b1;
                tlq_pkg::REQ_CHECK:
                    promote();
                default:
                    ;
            endcase
            o.ready_res = (hi_cnt > 0 || lo_cnt > 0);
            pending = {pending, o};
        endfunction

        function void check(outcome_t got);
            outcome_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result transfer %p", $time, got);
                errors++;
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got !== exp)
            begin
                $display("%0t: mismatch expected %p actual %p", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    tlq_req_if req ();
    tlq_res_if res ();

    two_level_queue_with_timed_entries u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source)
    );

    queue_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("two_level_queue_with_timed_entries_test: done, errors");
        $finish;
    end

    // receiver: ready changes at the falling edge
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res.ready = 1'b0;
            end
            else
                res.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && res.valid && res.ready)
            sb.check('{res.found, res.out_item, res.was_high, res.dropped_count,
                       res.ready_res, res.rejected});

    task automatic send(logic [tlq_pkg::REQ_W-1:0] code,
                        logic [tlq_pkg::HANDLE_W-1:0] handle,
                        logic [tlq_pkg::DELAY_W-1:0] delay, logic purge);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid         = 1'b1;
        req.req_type      = code;
        req.item          = handle;
        req.delay_ms      = delay;
        req.purge_on_high = purge;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note(code, handle, delay, purge);
    endtask

    task automatic random_items(int count);
        int w;
        logic [tlq_pkg::DELAY_W-1:0] delay;
        logic [tlq_pkg::REQ_W-1:0] code;
        for (int k = 0; k < count; k++)
        begin
            w = $urandom_range(99);
            if ($urandom_range(99) < 2)
            begin
                code = (w < 33) ? tlq_pkg::REQ_PUSH_HIGH
                     : (w < 66) ? tlq_pkg::REQ_PUSH_LOW : tlq_pkg::REQ_PUSH_FUTURE;
                for (int j = 0; j < 18; j++)
                    send(code, $urandom, tlq_pkg::DELAY_W'($urandom_range(0, 6)), 1'b0);
                continue;
            end
            w = $urandom_range(99);
            if ($urandom_range(9) < 7)
                delay = tlq_pkg::DELAY_W'($urandom_range(0, 8));
            else if ($urandom_range(1))
                delay = tlq_pkg::DELAY_W'($urandom_range(0, 40));
            else
                delay = tlq_pkg::DELAY_W'($urandom);
            if (w < 12)
                code = tlq_pkg::REQ_PUSH_HIGH;
            else if (w < 30)
                code = tlq_pkg::REQ_PUSH_LOW;
            else if (w < 50)
                code = tlq_pkg::REQ_PUSH_FUTURE;
            else if (w < 75)
                code = tlq_pkg::REQ_GET;
            else if (w < 90)
                code = tlq_pkg::REQ_TICK;
            else if (w < 97)
                code = tlq_pkg::REQ_CHECK;
            else
                code = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
            send(code, $urandom, delay, ($urandom_range(4) == 0));
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 14;
        recv_idle_pct = 59;
        hold_cycles = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = tlq_pkg::REQ_TICK;
        req.item = '0;
        req.delay_ms = '0;
        req.purge_on_high = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every code, purge, spare codes, full stores
        send(tlq_pkg::REQ_GET, '1, '1, 1'b1);
        send(tlq_pkg::REQ_PUSH_HIGH, '0, '0, 1'b0);
        send(tlq_pkg::REQ_PUSH_HIGH, '1, '1, 1'b1);
        send(tlq_pkg::REQ_PUSH_LOW, 32'h5a5a_a5a5, '0, 1'b0);
        send(tlq_pkg::REQ_PUSH_FUTURE, 32'h1234_5678, '0, 1'b0);
        send(tlq_pkg::REQ_PUSH_FUTURE, 32'hdead_beef, '1, 1'b0);
        send(tlq_pkg::REQ_PUSH_FUTURE, 32'h0000_0001, 16'd1, 1'b0);
        send(tlq_pkg::REQ_CHECK, '0, '0, 1'b0);
        send(tlq_pkg::REQ_TICK, '1, '1, 1'b1);
        send(tlq_pkg::REQ_GET, '0, '0, 1'b0);
        send(tlq_pkg::REQ_GET, '0, '0, 1'b1);
        send(tlq_pkg::REQ_GET, '0, '0, 1'b0);
        send(REQ_SPARE_LO, '1, '1, 1'b1);
        send(REQ_SPARE_HI, '0, '0, 1'b0);
        for (int j = 0; j < 17; j++)
            send(tlq_pkg::REQ_PUSH_HIGH, $urandom, '0, 1'b0);
        for (int j = 0; j < 17; j++)
            send(tlq_pkg::REQ_PUSH_LOW, $urandom, '0, 1'b0);
        for (int j = 0; j < 17; j++)
            send(tlq_pkg::REQ_PUSH_FUTURE, $urandom, tlq_pkg::DELAY_W'(j % 3), 1'b0);
        // low store full: promotion has to stop and resume later
        send(tlq_pkg::REQ_CHECK, '0, '0, 1'b0);
        send(tlq_pkg::REQ_PUSH_HIGH, $urandom, '0, 1'b0);
        for (int j = 0; j < 20; j++)
            send(tlq_pkg::REQ_GET, '0, '0, 1'b0);
        send(tlq_pkg::REQ_TICK, '0, '0, 1'b0);
        send(tlq_pkg::REQ_TICK, '0, '0, 1'b0);
        send(tlq_pkg::REQ_CHECK, '0, '0, 1'b0);
        send(tlq_pkg::REQ_GET, '0, '0, 1'b1);

        random_items(240);
        send_idle_pct = 59;
        recv_idle_pct = 14;
        random_items(240);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 400;
        random_items(240);

        @(negedge clk);
        req.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (sb.errors == 0)
            $display("two_level_queue_with_timed_entries_test: done, clean");
        else
            $display("two_level_queue_with_timed_entries_test: done, errors");
        $finish;
    end
endmodule
